@@ rtl/rau_pkg.sv @@
// package for the rational arithmetic unit: request and result types, codes
`timescale 1ns / 1ps
`default_nettype none
package rau_pkg;
  localparam int unsigned WordBitsDefault = 32;

  typedef enum logic [2:0] {
    OpNorm = 3'd0,
    OpAdd  = 3'd1,
    OpSub  = 3'd2,
    OpMul  = 3'd3,
    OpDiv  = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    StOk     = 2'd0,
    StZero   = 2'd1,
    StOvf    = 2'd2,
    StUnused = 2'd3
  } status_e;

  typedef struct packed {
    logic [2:0]  req_type;
    logic signed [31:0] a_num;
    logic signed [31:0] a_den;
    logic signed [31:0] b_num;
    logic signed [31:0] b_den;
  } req_t;

  typedef struct packed {
    logic signed [31:0] res_num;
    logic [30:0]        res_den;
    logic [1:0]         status;
  } res_t;
endpackage
`default_nettype wire

@@ rtl/rational_arith_unit.sv @@
// rational arithmetic unit top level: operand setup, gcd sequencer, result register
//
// usage: one request channel (req_valid_i/req_stall_o/req_i) carries an operation
// and two fractions a and b; one result channel (res_valid_o/res_stall_i/res_o)
// returns the reduced fraction and a status.
// a request is taken when req_valid_i is high and req_stall_o low. the block then
// works on it alone: up to three cross products come from one 32x32 multiplier,
// then the sum for add and subtract, then a gcd by repeated remainder on one shared
// restoring divider, and two exact divisions on the same divider.
// a zero denominator, or a zero b numerator on divide, goes straight to the
// output state with the zero status.
// the sequencer returns to idle when the result is loaded, and takes the next request there.
// the result sits in an output register until res_stall_i is low; a finished
// result waits in the sequencer while that register is still full.
// reset clears the sequencer and the result valid; no request is in flight after it.
`timescale 1ns / 1ps
`default_nettype none
module rational_arith_unit #(
  parameter int unsigned WordBits = rau_pkg::WordBitsDefault
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          req_valid_i,
  output logic               req_stall_o,
  input  wire rau_pkg::req_t req_i,
  output logic               res_valid_o,
  input  wire logic          res_stall_i,
  output rau_pkg::res_t      res_o
);
  typedef enum logic [10:0] {
    SIdle  = 11'b00000000001,
    SMul0  = 11'b00000000010,
    SMul1  = 11'b00000000100,
    SMul2  = 11'b00000001000,
    SMul3  = 11'b00000010000,
    SSum   = 11'b00000100000,
    SGcd   = 11'b00001000000,
    SGwait = 11'b00010000000,
    SDivN  = 11'b00100000000,
    SDivD  = 11'b01000000000,
    SOut   = 11'b10000000000
  } state_e;

  localparam logic [63:0] Lim = 64'd1 << (WordBits - 1);

  state_e      state_q, state_d;
  logic [2:0]  op_q, op_d;
  logic [31:0] an_q, ad_q, bn_q, bd_q, an_d, ad_d, bn_d, bd_d;
  logic        ann_q, adn_q, bnn_q, bdn_q, ann_d, adn_d, bnn_d, bdn_d;
  logic [63:0] p_q, p_d, nm_q, nm_d, dm_q, dm_d, x_q, x_d, y_q, y_d, g_q, g_d;
  logic        pn_q, pn_d, nneg_q, nneg_d;
  logic        rvalid_q, rvalid_d;
  rau_pkg::res_t res_q, res_d;
  rau_pkg::res_t out_q, out_d;

  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic        dv_start, dv_done;
  logic [63:0] dv_a, dv_b, dv_q, dv_r;

  function automatic logic [32:0] word_in(input logic [31:0] raw);
    logic [31:0] v, m;
    logic        s;
    v = raw & ((WordBits == 32) ? 32'hFFFF_FFFF : ((32'd1 << WordBits) - 32'd1));
    s = v[WordBits-1];
    m = s ? ((~v + 32'd1) & ((WordBits == 32) ? 32'hFFFF_FFFF
                                                  : ((32'd1 << WordBits) - 32'd1))) : v;
    if (s && m == 32'd0) m = 32'd1 << (WordBits - 1);
    return {s, m};
  endfunction

  logic [32:0] w_an, w_ad, w_bn, w_bd;
  assign w_an = word_in(req_i.a_num);
  assign w_ad = word_in(req_i.a_den);
  assign w_bn = word_in(req_i.b_num);
  assign w_bd = word_in(req_i.b_den);

  assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};

  rau_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (dv_start),
    .dividend_i (dv_a),
    .divisor_i  (dv_b),
    .done_o     (dv_done),
    .quot_o     (dv_q),
    .rem_o      (dv_r)
  );

  logic [2:0] op_in;
  always_comb begin
    op_in = req_i.req_type;
    if (op_in > 3'(rau_pkg::OpDiv)) op_in = 3'(rau_pkg::OpNorm);
  end

  logic [64:0] sum_mag;
  logic        sum_neg;
  logic        tn_neg, tb_neg;
  always_comb begin
    tb_neg = nm_q == 64'd0 ? 1'b0 : pn_q;
    tn_neg = p_q == 64'd0 ? 1'b0 : nneg_q;
    if (tn_neg == tb_neg) begin
      sum_mag = {1'b0, nm_q} + {1'b0, p_q};
      sum_neg = tn_neg;
    end else if (p_q >= nm_q) begin
      sum_mag = {1'b0, p_q - nm_q};
      sum_neg = tn_neg;
    end else begin
      sum_mag = {1'b0, nm_q - p_q};
      sum_neg = tb_neg;
    end
  end

  always_comb begin
    state_d  = state_q;
    op_d = op_q;
    an_d = an_q; ad_d = ad_q; bn_d = bn_q; bd_d = bd_q;
    ann_d = ann_q; adn_d = adn_q; bnn_d = bnn_q; bdn_d = bdn_q;
    p_d = p_q; pn_d = pn_q; nm_d = nm_q; dm_d = dm_q; nneg_d = nneg_q;
    x_d = x_q; y_d = y_q; g_d = g_q;
    rvalid_d = rvalid_q;
    res_d    = res_q;
    out_d    = out_q;
    mul_a    = an_q;
    mul_b    = bd_q;
    dv_start = 1'b0;
    dv_a     = x_q;
    dv_b     = y_q;
    if (rvalid_q && !res_stall_i) rvalid_d = 1'b0;
    unique case (state_q)
      SIdle: begin
        if (req_valid_i) begin
          op_d = op_in;
          {ann_d, an_d} = w_an; {adn_d, ad_d} = w_ad;
          {bnn_d, bn_d} = w_bn; {bdn_d, bd_d} = w_bd;
          if (op_in == 3'(rau_pkg::OpSub)) bnn_d = ~w_bn[32];
          if (w_ad[31:0] == 32'd0 ||
              (op_in != 3'(rau_pkg::OpNorm) && w_bd[31:0] == 32'd0) ||
              (op_in == 3'(rau_pkg::OpDiv) && w_bn[31:0] == 32'd0)) begin
            res_d = '{res_num: '0, res_den: '0, status: rau_pkg::StZero};
            state_d = SOut;
          end else if (op_in == 3'(rau_pkg::OpNorm)) begin
            nm_d = {32'd0, w_an[31:0]}; nneg_d = w_an[32];
            dm_d = {32'd0, w_ad[31:0]}; pn_d = w_ad[32];
            state_d = SMul3;
          end else begin
            state_d = SMul0;
          end
        end
      end
      SMul0: begin
        // first product: a_num*b_den, or a_num*b_num for multiply
        mul_a = an_q;
        mul_b = (op_q == 3'(rau_pkg::OpMul)) ? bn_q : bd_q;
        p_d   = mul_p;
        nneg_d = ann_q ^ ((op_q == 3'(rau_pkg::OpMul)) ? bnn_q : bdn_q);
        state_d = SMul1;
      end
      SMul1: begin
        mul_a = ad_q;
        mul_b = (op_q == 3'(rau_pkg::OpDiv)) ? bn_q : bd_q;
        dm_d  = mul_p;
        pn_d  = adn_q ^ ((op_q == 3'(rau_pkg::OpDiv)) ? bnn_q : bdn_q);
        if (op_q == 3'(rau_pkg::OpAdd) || op_q == 3'(rau_pkg::OpSub)) begin
          state_d = SMul2;
        end else begin
          nm_d = p_q;
          state_d = SMul3;
        end
      end
      SMul2: begin
        mul_a = bn_q;
        mul_b = ad_q;
        nm_d  = mul_p;
        pn_d  = bnn_q ^ adn_q;
        x_d   = dm_q;
        state_d = SSum;
      end
      SSum: begin
        nm_d   = sum_mag[63:0];
        nneg_d = sum_neg;
        pn_d   = bdn_q ^ adn_q;
        state_d = SMul3;
      end
      SMul3: begin
        // numerator in nm, denominator in dm, signs in nneg and pn
        if (nm_q == 64'd0) begin
          res_d = '{res_num: '0, res_den: 31'd1, status: rau_pkg::StOk};
          state_d = SOut;
        end else begin
          nneg_d = nneg_q ^ pn_q;
          x_d = nm_q;
          y_d = dm_q;
          state_d = SGcd;
        end
      end
      SGcd: begin
        if (y_q == 64'd0) begin
          g_d = x_q;
          dv_start = 1'b1;
          dv_a = nm_q;
          dv_b = x_q;
          state_d = SDivN;
        end else begin
          dv_start = 1'b1;
          state_d = SGwait;
        end
      end
      SGwait: begin
        if (dv_done) begin
          x_d = y_q;
          y_d = dv_r;
          state_d = SGcd;
        end
      end
      SDivN: begin
        if (dv_done) begin
          nm_d = dv_q;
          dv_start = 1'b1;
          dv_a = dm_q;
          dv_b = g_q;
          state_d = SDivD;
        end
      end
      SDivD: begin
        if (dv_done) begin
          if (dv_q > Lim - 64'd1 ||
              (nneg_q ? (nm_q > Lim) : (nm_q > Lim - 64'd1))) begin
            res_d = '{res_num: '0, res_den: '0, status: rau_pkg::StOvf};
          end else begin
            res_d.res_num = nneg_q ? (~nm_q[31:0] + 32'd1) : nm_q[31:0];
            res_d.res_den = dv_q[30:0];
            res_d.status  = rau_pkg::StOk;
          end
          state_d = SOut;
        end
      end
      SOut: begin
        if (!rvalid_q || !res_stall_i) begin
          out_d    = res_q;
          rvalid_d = 1'b1;
          state_d = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= SIdle;
      rvalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rvalid_q <= rvalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d;
    an_q <= an_d; ad_q <= ad_d; bn_q <= bn_d; bd_q <= bd_d;
    ann_q <= ann_d; adn_q <= adn_d; bnn_q <= bnn_d; bdn_q <= bdn_d;
    p_q <= p_d; pn_q <= pn_d; nm_q <= nm_d; dm_q <= dm_d; nneg_q <= nneg_d;
    x_q <= x_d; y_q <= y_d; g_q <= g_d;
    res_q <= res_d;
    out_q <= out_d;
  end

  assign req_stall_o = (state_q != SIdle);
  assign res_valid_o = rvalid_q;
  assign res_o       = out_q;

`ifndef SYNTHESIS
  a_result_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.status != rau_pkg::StOk |-> res_o.res_den == 31'd0)
    else $error("error result with nonzero denominator");
  a_result_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.status == rau_pkg::StOk |-> res_o.res_den != 31'd0)
    else $error("ok result with zero denominator");
  a_take_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && !req_stall_o |=> state_q != SIdle)
    else $error("request taken but sequencer idle");
`endif
endmodule
`default_nettype wire

@@ rtl/rau_divider.sv @@
// shared restoring divider, one quotient bit per cycle, 64-bit operands
`timescale 1ns / 1ps
`default_nettype none
module rau_divider (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [63:0] dividend_i,
  input  wire logic [63:0] divisor_i,
  output logic             done_o,
  output logic [63:0]      quot_o,
  output logic [63:0]      rem_o
);
  logic [63:0] quot_q, quot_d, rem_q, rem_d, dvs_q, dvs_d;
  logic [6:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [64:0] trial;
  logic [64:0] shifted;

  always_comb begin
    quot_d  = quot_q;
    rem_d   = rem_q;
    dvs_d   = dvs_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    shifted = {rem_q, quot_q[63]};
    trial   = shifted - {1'b0, dvs_q};
    if (start_i) begin
      quot_d = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
      cnt_d  = 7'd0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[64]) begin
        rem_d  = trial[63:0];
        quot_d = {quot_q[62:0], 1'b1};
      end else begin
        rem_d  = shifted[63:0];
        quot_d = {quot_q[62:0], 1'b0};
      end
      cnt_d = cnt_q + 7'd1;
      if (cnt_q == 7'd63) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;
endmodule
`default_nettype wire
